// ----- sv/lctw_pkg.sv -----
// shared types, constants and lookup functions for the lcd text command writer
package lctw_pkg;

   localparam int CHAR_W = 8;
   localparam int WIDTH_W = 6;
   localparam int COUNT_W = 8;
   localparam int LINE_W = 2;
   localparam int SHIFT_W = 6;
   localparam int RUN_W = 6;
   localparam int THR_W = 9;
   localparam int CSR_ADDR_W = 2;

   localparam logic [RUN_W-1:0] MAX_RUN = 6'd62;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

   localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'd10;
   localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'd8;
   localparam logic [CHAR_W-1:0] CMD_CLEAR = 8'h01;
   localparam logic [CHAR_W-1:0] CMD_HOME = 8'h02;
   localparam logic [CHAR_W-1:0] CMD_SHIFT_LEFT = 8'h10;
   localparam logic [CHAR_W-1:0] CMD_SHIFT_RIGHT = 8'h14;
   localparam logic [CHAR_W-1:0] CMD_DDRAM = 8'h80;
   localparam logic [CHAR_W-1:0] DATA_SPACE = 8'h20;

   localparam logic RS_COMMAND = 1'b0;
   localparam logic RS_DATA = 1'b1;

   localparam logic [WIDTH_W-1:0] LINE_WIDTH_RESET = 6'd20;
   localparam logic [CSR_ADDR_W-1:0] CSR_LINE_WIDTH_ADDR = 2'd0;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_HOME,
      ST_ADDR0,
      ST_ADVANCE,
      ST_BODY,
      ST_SHIFT,
      ST_BS_SPACE,
      ST_BS_LEFT1,
      ST_BS_LEFT2,
      ST_FINISH
   } state_type;

   typedef enum logic [2:0] {
      EM_CLEAR,
      EM_HOME,
      EM_ADDR0,
      EM_ADDR_NEXT,
      EM_SHIFT_LEFT,
      EM_SPACE,
      EM_SHIFT_RIGHT,
      EM_DATA
   } emit_sel_type;

   typedef struct packed {
      logic         take;
      logic         emit;
      emit_sel_type emit_sel;
      logic         push_last;
      logic         set_overflow;
      logic         line_inc;
      logic         inc_count;
      logic         load_shift;
      logic         dec_shift;
   } ctrl_type;

   typedef struct packed {
      logic in_valid;
      logic in_start;
      logic overflow;
      logic line_full;
      logic last_line;
      logic is_newline;
      logic is_backspace;
      logic shift_zero;
      logic pend_valid;
      logic out_free;
   } status_type;

   function automatic logic [CHAR_W-1:0] line_offset(input logic [LINE_W-1:0] line);
      logic [CHAR_W-1:0] res;
      case (line)
         2'd0: res = 8'h00;
         2'd1: res = 8'h40;
         2'd2: res = 8'h14;
         2'd3: res = 8'h54;
         default: res = 8'h00;
      endcase
      return res;
   endfunction

   function automatic logic [SHIFT_W-1:0] line_shifts(input logic [LINE_W-1:0] line);
      logic [SHIFT_W-1:0] res;
      case (line)
         2'd0: res = 6'd0;
         2'd1: res = 6'd40;
         2'd2: res = 6'd20;
         2'd3: res = 6'd60;
         default: res = 6'd0;
      endcase
      return res;
   endfunction

endpackage

// ----- sv/lctw_req_if.sv -----
// character input channel of the lcd text command writer
interface lctw_req_if;
   import lctw_pkg::*;

   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] character;
   logic              message_start;

   modport source (output valid, output character, output message_start, input ready);
   modport sink (input valid, input character, input message_start, output ready);
endinterface

// ----- sv/lctw_rsp_if.sv -----
// lcd bus transfer output channel of the lcd text command writer
interface lctw_rsp_if;
   import lctw_pkg::*;

   logic              valid;
   logic              ready;
   logic              register_select;
   logic [CHAR_W-1:0] bus_byte;
   logic              long_wait;
   logic              run_last;

   modport source (output valid, output register_select, output bus_byte,
                   output long_wait, output run_last, input ready);
   modport sink (input valid, input register_select, input bus_byte,
                 input long_wait, input run_last, output ready);
endinterface

// ----- sv/lctw_controller.sv -----
// sequencing state machine for the lcd text command writer
module lctw_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  lctw_pkg::status_type  status,
   output lctw_pkg::ctrl_type    ctrl
);
   import lctw_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (status.in_valid) begin
               state_in = status.in_start ? ST_CLEAR : ST_ADVANCE;
            end
         end
         ST_CLEAR: begin
            if (status.out_free) state_in = ST_HOME;
         end
         ST_HOME: begin
            if (status.out_free) state_in = ST_ADDR0;
         end
         ST_ADDR0: begin
            if (status.out_free) state_in = ST_ADVANCE;
         end
         ST_ADVANCE: begin
            if (status.overflow) begin
               state_in = ST_FINISH;
            end else if (!status.line_full) begin
               state_in = ST_BODY;
            end
         end
         ST_BODY: begin
            if (status.is_newline) begin
               if (status.last_line) begin
                  state_in = ST_FINISH;
               end else if (status.out_free) begin
                  state_in = ST_SHIFT;
               end
            end else if (status.out_free) begin
               state_in = status.is_backspace ? ST_BS_SPACE : ST_FINISH;
            end
         end
         ST_SHIFT: begin
            if (status.shift_zero) state_in = ST_FINISH;
         end
         ST_BS_SPACE: begin
            if (status.out_free) state_in = ST_BS_LEFT1;
         end
         ST_BS_LEFT1: begin
            if (status.out_free) state_in = ST_BS_LEFT2;
         end
         ST_BS_LEFT2: begin
            if (status.out_free) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!status.pend_valid || status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl = '0;
      ctrl.emit_sel = EM_DATA;
      case (state_ff)
         ST_IDLE: begin
            ctrl.take = 1'b1;
         end
         ST_CLEAR: begin
            ctrl.emit = status.out_free;
            ctrl.emit_sel = EM_CLEAR;
         end
         ST_HOME: begin
            ctrl.emit = status.out_free;
            ctrl.emit_sel = EM_HOME;
         end
         ST_ADDR0: begin
            ctrl.emit = status.out_free;
            ctrl.emit_sel = EM_ADDR0;
         end
         ST_ADVANCE: begin
            ctrl.emit_sel = EM_ADDR_NEXT;
            if (!status.overflow && status.line_full) begin
               if (status.last_line) begin
                  ctrl.set_overflow = 1'b1;
               end else if (status.out_free) begin
                  ctrl.emit = 1'b1;
                  ctrl.line_inc = 1'b1;
               end
            end
         end
         ST_BODY: begin
            if (status.is_newline) begin
               ctrl.emit_sel = EM_HOME;
               if (status.last_line) begin
                  ctrl.inc_count = 1'b1;
               end else if (status.out_free) begin
                  ctrl.emit = 1'b1;
                  ctrl.line_inc = 1'b1;
                  ctrl.load_shift = 1'b1;
                  ctrl.inc_count = 1'b1;
               end
            end else begin
               ctrl.emit_sel = status.is_backspace ? EM_SHIFT_LEFT : EM_DATA;
               ctrl.emit = status.out_free;
               ctrl.inc_count = status.out_free;
            end
         end
         ST_SHIFT: begin
            ctrl.emit_sel = EM_SHIFT_RIGHT;
            if (!status.shift_zero && status.out_free) begin
               ctrl.emit = 1'b1;
               ctrl.dec_shift = 1'b1;
            end
         end
         ST_BS_SPACE: begin
            ctrl.emit = status.out_free;
            ctrl.emit_sel = EM_SPACE;
         end
         ST_BS_LEFT1: begin
            ctrl.emit = status.out_free;
            ctrl.emit_sel = EM_SHIFT_LEFT;
         end
         ST_BS_LEFT2: begin
            ctrl.emit = status.out_free;
            ctrl.emit_sel = EM_SHIFT_LEFT;
         end
         ST_FINISH: begin
            ctrl.push_last = status.pend_valid && status.out_free;
         end
         default: ctrl = '0;
      endcase
   end

endmodule

// ----- sv/lctw_datapath.sv -----
// line tracking, transfer generation and output staging for the lcd text command writer
module lctw_datapath #(
   parameter int NUM_LINES = 4
) (
   input  logic                               clock,
   input  logic                               reset,
   input  lctw_pkg::ctrl_type                 ctrl,
   output lctw_pkg::status_type               status,
   input  logic [lctw_pkg::WIDTH_W-1:0]       line_width,
   lctw_req_if.sink                           req,
   lctw_rsp_if.source                         rsp
);
   import lctw_pkg::*;

   localparam logic [LINE_W:0] LINES = (LINE_W+1)'(NUM_LINES);

   logic [CHAR_W-1:0]  char_ff, char_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [LINE_W-1:0]  line_ff, line_in;
   logic               overflow_ff, overflow_in;
   logic [SHIFT_W-1:0] shift_ff, shift_in;
   logic [RUN_W-1:0]   run_ff, run_in;
   logic               pend_valid_ff, pend_valid_in;
   logic               pend_rs_ff, pend_rs_in;
   logic [CHAR_W-1:0]  pend_byte_ff, pend_byte_in;
   logic               out_valid_ff, out_valid_in;
   logic               out_rs_ff, out_rs_in;
   logic [CHAR_W-1:0]  out_byte_ff, out_byte_in;
   logic               out_last_ff, out_last_in;

   logic [LINE_W-1:0]  line_next;
   logic [THR_W-1:0]   threshold;
   logic               emit_rs;
   logic [CHAR_W-1:0]  emit_byte;
   logic               out_free;

   assign line_next = line_ff + LINE_W'(1);
   assign threshold = (THR_W'(line_ff) + THR_W'(1)) * THR_W'(line_width);
   assign out_free = !out_valid_ff || rsp.ready;

   always_comb begin
      emit_rs = RS_COMMAND;
      emit_byte = char_ff;
      case (ctrl.emit_sel)
         EM_CLEAR:       emit_byte = CMD_CLEAR;
         EM_HOME:        emit_byte = CMD_HOME;
         EM_ADDR0:       emit_byte = CMD_DDRAM | line_offset(LINE_W'(0));
         EM_ADDR_NEXT:   emit_byte = CMD_DDRAM | line_offset(line_next);
         EM_SHIFT_LEFT:  emit_byte = CMD_SHIFT_LEFT;
         EM_SHIFT_RIGHT: emit_byte = CMD_SHIFT_RIGHT;
         EM_SPACE: begin
            emit_rs = RS_DATA;
            emit_byte = DATA_SPACE;
         end
         EM_DATA: begin
            emit_rs = RS_DATA;
            emit_byte = char_ff;
         end
         default: emit_byte = char_ff;
      endcase
   end

   always_comb begin
      status.in_valid = req.valid;
      status.in_start = req.message_start;
      status.overflow = overflow_ff;
      status.line_full = THR_W'(count_ff) >= threshold;
      status.last_line = ((LINE_W+1)'(line_ff) + (LINE_W+1)'(1)) >= LINES;
      status.is_newline = char_ff == CHAR_NEWLINE;
      status.is_backspace = char_ff == CHAR_BACKSPACE;
      status.shift_zero = shift_ff == '0;
      status.pend_valid = pend_valid_ff;
      status.out_free = out_free;
   end

   always_comb begin
      char_in = char_ff;
      count_in = count_ff;
      line_in = line_ff;
      overflow_in = overflow_ff;
      shift_in = shift_ff;
      run_in = run_ff;
      pend_valid_in = pend_valid_ff;
      pend_rs_in = pend_rs_ff;
      pend_byte_in = pend_byte_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      out_rs_in = out_rs_ff;
      out_byte_in = out_byte_ff;
      out_last_in = out_last_ff;

      if (ctrl.take && req.valid) begin
         char_in = req.character;
         run_in = '0;
         if (req.message_start) begin
            count_in = '0;
            line_in = '0;
            overflow_in = 1'b0;
         end
      end
      if (ctrl.set_overflow) overflow_in = 1'b1;
      if (ctrl.line_inc) line_in = line_next;
      if (ctrl.inc_count && count_ff != COUNT_MAX) count_in = count_ff + COUNT_W'(1);
      if (ctrl.load_shift) shift_in = line_shifts(line_next);
      if (ctrl.dec_shift) shift_in = shift_ff - SHIFT_W'(1);

      if (ctrl.emit && run_ff != MAX_RUN) begin
         run_in = run_ff + RUN_W'(1);
         pend_valid_in = 1'b1;
         pend_rs_in = emit_rs;
         pend_byte_in = emit_byte;
         if (pend_valid_ff) begin
            out_valid_in = 1'b1;
            out_rs_in = pend_rs_ff;
            out_byte_in = pend_byte_ff;
            out_last_in = 1'b0;
         end
      end
      if (ctrl.push_last) begin
         out_valid_in = 1'b1;
         out_rs_in = pend_rs_ff;
         out_byte_in = pend_byte_ff;
         out_last_in = 1'b1;
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         line_ff <= '0;
         overflow_ff <= 1'b0;
         shift_ff <= '0;
         run_ff <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         line_ff <= line_in;
         overflow_ff <= overflow_in;
         shift_ff <= shift_in;
         run_ff <= run_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      pend_rs_ff <= pend_rs_in;
      pend_byte_ff <= pend_byte_in;
      out_rs_ff <= out_rs_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   assign req.ready = ctrl.take;
   assign rsp.valid = out_valid_ff;
   assign rsp.register_select = out_rs_ff;
   assign rsp.bus_byte = out_byte_ff;
   assign rsp.long_wait = (out_rs_ff == RS_COMMAND) &&
                          (out_byte_ff == CMD_CLEAR || out_byte_ff == CMD_HOME);
   assign rsp.run_last = out_last_ff;

endmodule

// ----- sv/lcd_text_command_writer.sv -----
// lcd text command writer: one character in, a run of lcd bus transfers out
// staging: each transfer is held in a pending register and moves to the output register when the
// next transfer is generated or the run finishes; a stalled receiver holds the run back
// throughput: one character per run; a new character is taken only once its run has finished
// reset: synchronous; clears line, count and overflow state, line width back to 20
module lcd_text_command_writer #(
   parameter int NUM_LINES = 4
) (
   input  logic                                 clock,
   input  logic                                 reset,
   lctw_req_if.sink                             req_ch,
   lctw_rsp_if.source                           rsp_ch,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [lctw_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [31:0]                          csr_pwdata,
   output logic [31:0]                          csr_prdata,
   output logic                                 csr_pready
);
   import lctw_pkg::*;

   logic [WIDTH_W-1:0] line_width_ff, line_width_in;
   logic               csr_write;
   ctrl_type           ctrl;
   status_type         status;

   assign csr_pready = 1'b1;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      line_width_in = line_width_ff;
      if (csr_write && csr_paddr == CSR_LINE_WIDTH_ADDR) begin
         line_width_in = csr_pwdata[WIDTH_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff <= LINE_WIDTH_RESET;
      end else begin
         line_width_ff <= line_width_in;
      end
   end

   assign csr_prdata = (csr_paddr == CSR_LINE_WIDTH_ADDR) ? 32'(line_width_ff) : 32'd0;

   lctw_controller u_controller (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   lctw_datapath #(
      .NUM_LINES (NUM_LINES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .status     (status),
      .line_width (line_width_ff),
      .req        (req_ch),
      .rsp        (rsp_ch)
   );

   a_take_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("second transaction taken while a run is in progress");

   a_no_emit_while_idle: assert property (@(posedge clock) disable iff (reset)
      ctrl.take |-> !ctrl.emit && !ctrl.push_last)
      else $error("transfer generated while waiting for a character");

   a_output_not_overwritten: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.ready) |=> rsp_ch.valid && $stable(rsp_ch.bus_byte))
      else $error("stalled transfer lost or changed");

endmodule

// ----- tb/tb_lcd_text_command_writer.sv -----
// self-checking testbench for the lcd text command writer: characters in, lcd transfers checked
module tb_lcd_text_command_writer;
   import lctw_pkg::*;

   localparam int QUIET_LIMIT = 4000;
   localparam int HOLD_CYCLES = 400;
   localparam int HOLD_AT = 60;
   localparam int SETTLE_CYCLES = 80;
   localparam int RUN_CAP = 62;

   typedef struct packed {
      logic              rs;
      logic [CHAR_W-1:0] data;
      logic              slow;
      logic              last;
   } lcd_xfer_type;

   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              start;
   } lcd_char_type;

   logic clock;
   logic reset;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic csr_pready;

   lctw_req_if req_ch ();
   lctw_rsp_if rsp_ch ();

   lcd_text_command_writer DUT (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // display model state
   logic [WIDTH_W-1:0] mdl_width;
   logic [COUNT_W-1:0] mdl_count;
   logic [2:0] mdl_line;
   logic mdl_overflow;
   logic [CHAR_W-1:0] ddram_base [4] = '{8'h00, 8'h40, 8'h14, 8'h54};
   int right_shifts [4] = '{0, 40, 20, 60};

   lcd_char_type pending_chars[$];
   lcd_xfer_type run_buf[$];
   lcd_xfer_type due_xfers[$];

   int errors = 0;
   int chars_taken = 0;
   logic req_taken = 1'b0;

   // sender pacing
   int burst_left = 0;
   int gap_left = 0;

   // receiver pacing
   int hold_left = 0;
   logic hold_done = 1'b0;
   int mode = 0;
   int mode_left = 0;
   int tick = 0;
   int quiet = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic string xfer_text(input lcd_xfer_type x);
      return $sformatf("rs=%0b byte=%02h wait=%0b last=%0b", x.rs, x.data, x.slow, x.last);
   endfunction

   function automatic void add_xfer(input logic rs, input logic [CHAR_W-1:0] b);
      lcd_xfer_type x;
      if (run_buf.size() < RUN_CAP) begin
         x.rs = rs;
         x.data = b;
         x.slow = (rs == RS_COMMAND) && (b == CMD_CLEAR || b == CMD_HOME);
         x.last = 1'b0;
         run_buf.push_back(x);
      end
   endfunction

   function automatic void predict_run(input lcd_char_type c);
      run_buf.delete();
      if (c.start) begin
         mdl_count = '0;
         mdl_line = '0;
         mdl_overflow = 1'b0;
         add_xfer(RS_COMMAND, CMD_CLEAR);
         add_xfer(RS_COMMAND, CMD_HOME);
         add_xfer(RS_COMMAND, CMD_DDRAM | ddram_base[0]);
      end
      // step past full lines
      while (!mdl_overflow && int'(mdl_count) >= (int'(mdl_line) + 1) * int'(mdl_width)) begin
         if (mdl_line >= 3) begin
            mdl_overflow = 1'b1;
         end else begin
            mdl_line++;
            add_xfer(RS_COMMAND, CMD_DDRAM | ddram_base[mdl_line[1:0]]);
         end
      end
      if (!mdl_overflow) begin
         if (c.ch == CHAR_NEWLINE) begin
            if (mdl_line < 3) begin
               mdl_line++;
               add_xfer(RS_COMMAND, CMD_HOME);
               for (int k = 0; k < right_shifts[mdl_line[1:0]]; k++)
                  add_xfer(RS_COMMAND, CMD_SHIFT_RIGHT);
            end
         end else if (c.ch == CHAR_BACKSPACE) begin
            add_xfer(RS_COMMAND, CMD_SHIFT_LEFT);
            add_xfer(RS_DATA, DATA_SPACE);
            add_xfer(RS_COMMAND, CMD_SHIFT_LEFT);
            add_xfer(RS_COMMAND, CMD_SHIFT_LEFT);
         end else begin
            add_xfer(RS_DATA, c.ch);
         end
         if (mdl_count != COUNT_MAX)
            mdl_count++;
      end
      if (run_buf.size() > 0)
         run_buf[$].last = 1'b1;
      foreach (run_buf[i])
         due_xfers.push_back(run_buf[i]);
   endfunction

   // transaction monitor and scoreboard
   always @(posedge clock) begin : observe
      lcd_xfer_type got;
      lcd_xfer_type want;
      if (reset) begin
         mdl_width = LINE_WIDTH_RESET;
         mdl_count = '0;
         mdl_line = '0;
         mdl_overflow = 1'b0;
         req_taken = 1'b0;
      end else begin
         req_taken = req_ch.valid && req_ch.ready;
         if (csr_psel && csr_penable && csr_pready && csr_pwrite
             && csr_paddr == CSR_LINE_WIDTH_ADDR)
            mdl_width = csr_pwdata[WIDTH_W-1:0];
         if (csr_psel && csr_penable && csr_pready && !csr_pwrite
             && csr_prdata[WIDTH_W-1:0] !== mdl_width) begin
            errors++;
            $display("%0t line_width read back: expected %0d, actual %0d",
                     $time, mdl_width, csr_prdata[WIDTH_W-1:0]);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = {rsp_ch.register_select, rsp_ch.bus_byte, rsp_ch.long_wait, rsp_ch.run_last};
            if (due_xfers.size() == 0) begin
               errors++;
               $display("%0t transfer with none expected: expected nothing, actual %s",
                        $time, xfer_text(got));
            end else begin
               want = due_xfers.pop_front();
               if (got !== want) begin
                  errors++;
                  $display("%0t transfer mismatch: expected %s, actual %s",
                           $time, xfer_text(want), xfer_text(got));
               end
            end
         end
         if (req_taken) begin
            chars_taken++;
            predict_run({req_ch.character, req_ch.message_start});
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || csr_psel) begin
         quiet = 0;
      end else begin
         quiet++;
         if (quiet >= QUIET_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // character driver, bursts with gaps
   always @(negedge clock) begin : tx_drive
      logic v;
      lcd_char_type c;
      v = req_ch.valid;
      c = {req_ch.character, req_ch.message_start};
      if (reset) begin
         v = 1'b0;
      end else if (!v || req_taken) begin
         v = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
         end else if (pending_chars.size() > 0) begin
            c = pending_chars.pop_front();
            v = 1'b1;
            if (burst_left <= 1) begin
               burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 24);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
               burst_left--;
            end
         end
      end
      req_ch.valid <= v;
      req_ch.character <= c.ch;
      req_ch.message_start <= c.start;
   end

   // receiver stall pattern, with one long hold-off
   always @(negedge clock) begin : rx_pace
      logic rdy;
      tick++;
      if (reset) begin
         rdy = 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rdy = 1'b0;
      end else if (!hold_done && chars_taken >= HOLD_AT) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES - 1;
         rdy = 1'b0;
      end else begin
         if (mode_left == 0) begin
            mode = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 120);
         end
         mode_left--;
         case (mode)
            0: rdy = 1'b1;
            1: rdy = 1'($urandom_range(0, 1));
            2: rdy = ($urandom_range(0, 3) == 0);
            default: rdy = (tick % 3 == 0);
         endcase
      end
      rsp_ch.ready <= rdy;
   end

   task automatic queue_char(input logic [CHAR_W-1:0] ch, input logic start);
      pending_chars.push_back({ch, start});
   endtask

   task automatic csr_write(input logic [WIDTH_W-1:0] w);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_LINE_WIDTH_ADDR;
      // upper bits are don't-care for the register
      csr_pwdata <= ($urandom() & ~32'h3F) | 32'(w);
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic drain_and_pause();
      do @(negedge clock);
      while (pending_chars.size() > 0 || req_ch.valid || due_xfers.size() > 0);
      // a dropped character leaves no transfer behind
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic logic [CHAR_W-1:0] pick_char();
      int r;
      logic [CHAR_W-1:0] ch;
      r = $urandom_range(0, 99);
      if (r < 8)
         ch = CHAR_NEWLINE;
      else if (r < 14)
         ch = CHAR_BACKSPACE;
      else if (r < 17)
         ch = 8'h00;
      else if (r < 27)
         ch = CHAR_W'($urandom_range(0, 255));
      else
         ch = CHAR_W'($urandom_range(8'h20, 8'h7E));
      return ch;
   endfunction

   task automatic fill_phase(input int w, input int n);
      int made;
      int len;
      logic fresh;
      made = 0;
      while (made < n) begin
         len = $urandom_range(1, (4 * w + 8 < 60) ? 4 * w + 8 : 60);
         fresh = (made == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 9) != 0);
         for (int i = 0; i < len && made < n; i++) begin
            queue_char(pick_char(), (i == 0 && fresh) || ($urandom_range(0, 49) == 0));
            made++;
         end
      end
   endtask

   initial begin : stimulus
      int w;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.character = '0;
      req_ch.message_start = 1'b0;
      rsp_ch.ready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // reset width: text before any message, then every kind of character
      queue_char(8'h41, 1'b0);
      queue_char(8'h48, 1'b1);
      queue_char(8'h00, 1'b0);
      queue_char(8'hFF, 1'b0);
      queue_char(CHAR_BACKSPACE, 1'b0);
      queue_char(CHAR_NEWLINE, 1'b0);
      queue_char(CHAR_NEWLINE, 1'b0);
      queue_char(CHAR_NEWLINE, 1'b0);
      queue_char(CHAR_NEWLINE, 1'b0);
      queue_char(8'h78, 1'b0);
      drain_and_pause();

      // zero width steps through every line address then drops
      csr_write(6'd0);
      queue_char(8'h51, 1'b1);
      queue_char(8'h52, 1'b0);
      drain_and_pause();

      // one character per line, overflow on the fifth
      csr_write(6'd1);
      queue_char(8'h61, 1'b1);
      queue_char(8'h62, 1'b0);
      queue_char(8'h63, 1'b0);
      queue_char(8'h64, 1'b0);
      queue_char(8'h65, 1'b0);
      queue_char(CHAR_NEWLINE, 1'b1);
      drain_and_pause();

      csr_write(6'd63);
      queue_char(8'h7F, 1'b1);
      queue_char(CHAR_BACKSPACE, 1'b0);
      queue_char(CHAR_NEWLINE, 1'b0);
      drain_and_pause();

      for (int p = 0; p < 5; p++) begin
         case (p)
            0: w = 40;
            1: w = $urandom_range(1, 8);
            2: w = 63;
            3: w = $urandom_range(0, 63);
            default: w = $urandom_range(9, 30);
         endcase
         csr_write(WIDTH_W'(w));
         fill_phase(w, 46);
         drain_and_pause();
      end

      if (errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ----- filelist.f -----
sv/lctw_pkg.sv
sv/lctw_req_if.sv
sv/lctw_rsp_if.sv
sv/lctw_controller.sv
sv/lctw_datapath.sv
sv/lcd_text_command_writer.sv
tb/tb_lcd_text_command_writer.sv
